### hw/rtl/bped_pkg.sv
// shared types, codes and constants of the button press event detector
package bped_pkg;

    // number of buttons with per-button state
    localparam int unsigned BUTTONS = 8;
    localparam int unsigned ENTRY_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    // event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PULL_UP_MASK  = 2'd0;
    localparam logic [1:0] CFG_HOLD_TIME     = 2'd1;
    localparam logic [1:0] CFG_BOUNCE_WINDOW = 2'd2;

    // configuration reset values
    localparam logic [7:0]  PULL_UP_MASK_RST  = 8'd255;
    localparam logic [15:0] HOLD_TIME_RST     = 16'd1000;
    localparam logic [9:0]  BOUNCE_WINDOW_RST = 10'd50;

    // one input item
    typedef struct packed {
        logic [2:0]  button_index;
        logic        pin_level;
        logic [31:0] now_ms;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [1:0] event_res;
        logic       click;
    } out_item_t;

    // per-button state word
    typedef struct packed {
        logic [31:0] event_time;
        logic        was_pressed;
        logic        long_reported;
        logic [1:0]  last_press_kind;
    } state_t;

    localparam state_t STATE_RST = '{
        event_time:      32'd0,
        was_pressed:     1'b0,
        long_reported:   1'b0,
        last_press_kind: EV_RELEASE
    };

endpackage

### hw/rtl/bped_update.sv
// per-button state update and event decision for one sample
module bped_update
(
    input  bped_pkg::state_t    cur,
    input  logic                pressed,
    input  logic [31:0]         now_ms,
    input  logic [15:0]         hold_time,
    input  logic [9:0]          bounce_window,
    output bped_pkg::state_t    nxt,
    output bped_pkg::out_item_t res
);

    logic [31:0] elapsed;
    logic        edge_ok;
    logic        long_ok;
    logic        click_ok;
    logic [1:0]  ev;

    // wrapping elapsed time since the last accepted event
    assign elapsed = now_ms - cur.event_time;

    // debounced edge, and long hold when no edge was taken
    assign edge_ok = (pressed != cur.was_pressed) && (elapsed > {22'd0, bounce_window});
    assign long_ok = !edge_ok && pressed && !cur.long_reported
                     && (elapsed > {16'd0, hold_time});

    always_comb
    begin
        nxt             = cur;
        nxt.was_pressed = pressed;
        ev              = bped_pkg::EV_NONE;
        if (edge_ok)
        begin
            nxt.event_time = now_ms;
            if (pressed)
            begin
                nxt.long_reported   = 1'b0;
                nxt.last_press_kind = bped_pkg::EV_PRESS;
                ev                  = bped_pkg::EV_PRESS;
            end
            else
            begin
                ev = bped_pkg::EV_RELEASE;
            end
        end
        if (long_ok)
        begin
            nxt.long_reported   = 1'b1;
            nxt.event_time      = now_ms;
            nxt.last_press_kind = bped_pkg::EV_LONG;
            ev                  = bped_pkg::EV_LONG;
        end
        // short press ended by this release
        click_ok = (ev == bped_pkg::EV_RELEASE)
                   && (cur.last_press_kind == bped_pkg::EV_PRESS);
        if (click_ok)
        begin
            nxt.last_press_kind = bped_pkg::EV_RELEASE;
        end
        res.event_res = ev;
        res.click     = click_ok;
    end

endmodule

### hw/rtl/button_press_event_detector.sv
// top level: debounced press, release, long hold and click detection per button
// input item to result item: state read into the update stage registers, then update into the output register
// throughput: one item per cycle while the output is not stalled; per-button state comes
// from one memory read registered at accept, with the last write forwarded to a following item
// reset: config registers to defaults, per-button valid bits cleared so every
// button reads its reset state; no clearing pass needed
module button_press_event_detector
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bped_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bped_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    // configuration registers
    logic [7:0]  pull_up_mask_reg;
    logic [15:0] hold_time_reg;
    logic [9:0]  bounce_window_reg;

    // state memory and valid bits
    bped_pkg::state_t state_mem [bped_pkg::BUTTONS];
    logic [bped_pkg::BUTTONS-1:0] vld_reg;

    // update stage registers
    logic                          s1_valid_reg;
    bped_pkg::in_item_t            s1_item_reg;
    bped_pkg::state_t              rd_data_reg;
    logic                          rd_vld_reg;

    // last write, forwarded to the next item
    logic                          fwd_valid_reg;
    logic [bped_pkg::ENTRY_W-1:0]  fwd_idx_reg;
    bped_pkg::state_t              fwd_data_reg;

    // output register
    logic                          out_valid_reg;
    bped_pkg::out_item_t           out_data_reg;

    logic                          in_accept;
    logic                          s1_adv;
    logic                          s1_in_range;
    logic [bped_pkg::ENTRY_W-1:0]  rd_addr;
    logic [bped_pkg::ENTRY_W-1:0]  s1_addr;
    bped_pkg::state_t              cur_state;
    bped_pkg::state_t              nxt_state;
    bped_pkg::out_item_t           upd_res;
    logic                          pressed;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rd_addr     = in_data.button_index[bped_pkg::ENTRY_W-1:0];
    assign s1_addr     = s1_item_reg.button_index[bped_pkg::ENTRY_W-1:0];
    assign s1_in_range = 32'(s1_item_reg.button_index) < bped_pkg::BUTTONS;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pull_up_mask_reg  <= bped_pkg::PULL_UP_MASK_RST;
            hold_time_reg     <= bped_pkg::HOLD_TIME_RST;
            bounce_window_reg <= bped_pkg::BOUNCE_WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bped_pkg::CFG_PULL_UP_MASK:  pull_up_mask_reg  <= cfg_data[7:0];
                bped_pkg::CFG_HOLD_TIME:     hold_time_reg     <= cfg_data;
                bped_pkg::CFG_BOUNCE_WINDOW: bounce_window_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // state memory: read on accept, write back when the update stage moves on
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_in_range)
        begin
            state_mem[s1_addr] <= nxt_state;
        end
        if (in_accept)
        begin
            rd_data_reg <= state_mem[rd_addr];
            s1_item_reg <= in_data;
        end
    end

    // valid bits, stage control and forwarding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            fwd_idx_reg   <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv && s1_in_range)
            begin
                vld_reg[s1_addr] <= 1'b1;
                fwd_valid_reg    <= 1'b1;
                fwd_idx_reg      <= s1_addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_in_range)
        begin
            fwd_data_reg <= nxt_state;
        end
    end

    // current state: forwarded write, stored entry, or reset value
    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == s1_addr))
        begin
            cur_state = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_state = rd_data_reg;
        end
        else
        begin
            cur_state = bped_pkg::STATE_RST;
        end
    end

    assign pressed = s1_item_reg.pin_level ^ pull_up_mask_reg[s1_item_reg.button_index];

    bped_update u_update
    (
        .cur           (cur_state),
        .pressed       (pressed),
        .now_ms        (s1_item_reg.now_ms),
        .hold_time     (hold_time_reg),
        .bounce_window (bounce_window_reg),
        .nxt           (nxt_state),
        .res           (upd_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            if (s1_in_range)
            begin
                out_data_reg <= upd_res;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty update stage");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("update stage advanced without producing a result");

    a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.click) |->
            (out_data_reg.event_res == bped_pkg::EV_RELEASE))
        else $error("click without release");

    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && upd_res.event_res == bped_pkg::EV_LONG) |->
            !cur_state.long_reported)
        else $error("long hold reported twice in one press");

endmodule

### dv/tb.sv
// self-checking testbench for the button press event detector
module tb;
    import bped_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PULL_UP_MASK;
    logic [15:0] cfg_data = '0;

    button_press_event_detector u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // shadow copy of the configuration registers
    logic [7:0]  pu_mask;
    logic [15:0] hold_ms;
    logic [9:0]  debounce_ms;

    // shadow copy of the per-button state
    logic [31:0] ev_time   [BUTTONS];
    logic        was_down  [BUTTONS];
    logic        long_done [BUTTONS];
    logic [1:0]  last_kind [BUTTONS];

    in_item_t    pending_samples [$];
    out_item_t   expected_events [$];

    int unsigned tx_gap_max = 7;
    int unsigned rx_gap_max = 7;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned idle_cycles = 0;
    logic [31:0] t_ms = '0;

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors = 0;
    int unsigned n_press = 0;
    int unsigned n_release = 0;
    int unsigned n_long = 0;
    int unsigned n_click = 0;
    int unsigned n_writes = 0;

    // event prediction for one sample, updates the shadow state
    function automatic out_item_t detect_event(input in_item_t s);
        out_item_t   r;
        int unsigned b;
        logic        down;
        r.event_res = EV_NONE;
        r.click = 1'b0;
        b = 32'(s.button_index);
        if (b >= BUTTONS)
            return r;
        down = s.pin_level ^ pu_mask[b];
        // debounced edge
        if (down != was_down[b] && (s.now_ms - ev_time[b]) > {22'd0, debounce_ms})
        begin
            ev_time[b] = s.now_ms;
            if (down)
            begin
                long_done[b] = 1'b0;
                r.event_res = EV_PRESS;
                last_kind[b] = EV_PRESS;
            end
            else
                r.event_res = EV_RELEASE;
        end
        // long hold, once per press
        if (down && !long_done[b] && (s.now_ms - ev_time[b]) > {16'd0, hold_ms})
        begin
            long_done[b] = 1'b1;
            ev_time[b] = s.now_ms;
            r.event_res = EV_LONG;
            last_kind[b] = EV_LONG;
        end
        // short press ended by this release
        if (r.event_res == EV_RELEASE && last_kind[b] == EV_PRESS)
        begin
            last_kind[b] = EV_RELEASE;
            r.click = 1'b1;
        end
        was_down[b] = down;
        return r;
    endfunction

    // time step around a threshold
    function automatic int unsigned step_near(input int unsigned lim);
        case ($urandom_range(0, 4))
            0: return lim;
            1: return lim + 1;
            2: return lim + 2;
            3: return $urandom_range(0, lim);
            default: return lim + $urandom_range(1, 64);
        endcase
    endfunction

    task automatic push_raw(input logic [2:0] b, input logic pin, input logic [31:0] now);
        in_item_t s;
        s.button_index = b;
        s.pin_level = pin;
        s.now_ms = now;
        pending_samples.push_back(s);
        n_queued++;
    endtask

    task automatic push_pressed(input logic [2:0] b, input logic down);
        push_raw(b, down ^ pu_mask[b], t_ms);
    endtask

    // one register write over the config channel
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PULL_UP_MASK:  pu_mask = val[7:0];
            CFG_HOLD_TIME:     hold_ms = val;
            CFG_BOUNCE_WINDOW: debounce_ms = val[9:0];
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
    endtask

    // wait until every sample is sent and every event is back
    task automatic wait_idle;
        while (pending_samples.size() != 0 || in_valid || expected_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random press sequences mixed with noise
    task automatic gen_samples(input int unsigned n);
        int unsigned start;
        logic [2:0]  b;
        int unsigned k;
        start = n_queued;
        while (n_queued - start < n)
        begin
            b = 3'($urandom_range(0, BUTTONS - 1));
            if ($urandom_range(0, 9) < 2)
            begin
                // noise on any button, sometimes a large time jump
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 7) == 0)
                        t_ms += $urandom;
                    else
                        t_ms += $urandom_range(0, 2 * debounce_ms + 2);
                    push_raw(3'($urandom_range(0, BUTTONS - 1)), 1'($urandom_range(0, 1)),
                             t_ms);
                end
            end
            else
            begin
                t_ms += step_near(32'(debounce_ms));
                push_pressed(b, 1'b1);
                // contact bounce right after the press
                if ($urandom_range(0, 3) == 0)
                begin
                    t_ms += $urandom_range(0, debounce_ms);
                    push_pressed(b, 1'b0);
                    t_ms += $urandom_range(0, 3);
                    push_pressed(b, 1'b1);
                end
                k = $urandom_range(0, 4);
                repeat (k)
                begin
                    if ($urandom_range(0, 1))
                        t_ms += step_near(32'(hold_ms));
                    else
                        t_ms += $urandom_range(0, hold_ms / 4 + 1);
                    push_pressed(b, 1'b1);
                    if ($urandom_range(0, 3) == 0)
                        push_raw(3'($urandom_range(0, BUTTONS - 1)),
                                 1'($urandom_range(0, 1)), t_ms);
                end
                t_ms += step_near(32'(debounce_ms));
                push_pressed(b, 1'b0);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] mask, input logic [15:0] hold,
                             input logic [15:0] deb, input int unsigned tx,
                             input int unsigned rx, input int unsigned n);
        write_reg(CFG_PULL_UP_MASK, {8'($urandom_range(0, 255)), mask});
        write_reg(CFG_HOLD_TIME, hold);
        write_reg(CFG_BOUNCE_WINDOW, deb);
        tx_gap_max = tx;
        rx_gap_max = rx;
        t_ms = $urandom;
        gen_samples(n);
        wait_idle();
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_events.push_back(detect_event(in_data));
                n_accepted++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the item until it is taken
            end
            else if (tx_wait != 0)
            begin
                tx_wait <= tx_wait - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                in_data <= pending_samples.pop_front();
                in_valid <= 1'b1;
                tx_wait <= $urandom_range(0, tx_gap_max);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // event monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin : watch
            int unsigned stall;
            out_item_t   want;
            stall = rx_wait;
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event item with no sample pending");
                    n_errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (out_data.event_res !== want.event_res)
                    begin
                        $error("event_res mismatch: expected %0d, got %0d",
                               want.event_res, out_data.event_res);
                        n_errors++;
                    end
                    if (out_data.click !== want.click)
                    begin
                        $error("click mismatch: expected %0d, got %0d",
                               want.click, out_data.click);
                        n_errors++;
                    end
                    case (want.event_res)
                        EV_PRESS:   n_press++;
                        EV_RELEASE: n_release++;
                        EV_LONG:    n_long++;
                        default: ;
                    endcase
                    if (want.click)
                        n_click++;
                end
                stall = $urandom_range(0, rx_gap_max);
            end
            else if (stall != 0)
                stall = stall - 1;
            rx_wait <= stall;
            out_ready <= (stall == 0);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus sequence
    initial
    begin
        pu_mask = PULL_UP_MASK_RST;
        hold_ms = HOLD_TIME_RST;
        debounce_ms = BOUNCE_WINDOW_RST;
        for (int i = 0; i < BUTTONS; i++)
        begin
            ev_time[i] = STATE_RST.event_time;
            was_down[i] = STATE_RST.was_pressed;
            long_done[i] = STATE_RST.long_reported;
            last_kind[i] = STATE_RST.last_press_kind;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed samples at reset settings
        push_raw(3'd0, 1'b1, 32'd0);
        push_raw(3'd0, 1'b0, 32'd10);            // edge inside debounce window
        push_raw(3'd0, 1'b0, 32'd2000);          // long hold without accepted press
        push_raw(3'd0, 1'b1, 32'd2051);          // release after long hold, no click
        push_raw(3'd1, 1'b0, 32'd100);
        push_raw(3'd1, 1'b0, 32'd500);
        push_raw(3'd1, 1'b1, 32'd600);           // short press gives click
        push_raw(3'd1, 1'b0, 32'd650);           // exactly at debounce, rejected
        push_raw(3'd1, 1'b1, 32'd651);           // edge against the rejected level
        push_raw(3'd1, 1'b1, 32'd700);
        push_raw(3'd7, 1'b0, 32'hFFFF_FFF0);
        push_raw(3'd7, 1'b0, 32'h0000_0400);     // long hold across time wrap
        push_raw(3'd7, 1'b1, 32'h0000_0500);
        push_raw(3'd7, 1'b0, 32'hFFFF_FFFF);
        push_raw(3'd7, 1'b1, 32'h0000_0100);     // click across time wrap
        push_raw(3'd3, 1'b1, 32'hFFFF_FFFF);
        push_raw(3'd3, 1'b0, 32'd0);
        push_raw(3'd3, 1'b0, 32'd1001);
        push_raw(3'd3, 1'b0, 32'd2100);
        wait_idle();

        // random phases over several settings, extremes first
        run_phase(8'h00, 16'd0, 16'd0, 7, 7, 120);
        run_phase(8'hA5, 16'hFFFF, 16'd1023, 0, 0, 120);
        write_reg(CFG_UNUSED, 16'hFFFF);
        run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(20, 300)),
                  {6'($urandom), 10'($urandom_range(1, 40))}, 7, 7, 150);
        run_phase(8'h5A, HOLD_TIME_RST, 16'hFC32, 7, 0, 150);
        run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 2000)),
                  16'($urandom_range(0, 100)), 0, 7, 150);

        $display("%0d samples checked over %0d register writes", n_accepted, n_writes);
        $display("events seen: %0d press, %0d release, %0d long hold, %0d click",
                 n_press, n_release, n_long, n_click);
        if (n_errors == 0 && expected_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
